// ----- src/tsp_pkg.sv -----
// types, constants and helper functions for the temperature stepper positioner
// no dependencies; imported by every module of the block
`default_nettype none

package tsp_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TEMP_W   = 9;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned INDEX_W  = 2;

  localparam logic [1:0] REG_HIGH_LIMIT   = 2'd0;
  localparam logic [1:0] REG_LOW_LIMIT    = 2'd1;
  localparam logic [1:0] REG_TOP_POSITION = 2'd2;

  localparam logic [8:0] HIGH_LIMIT_RESET   = 9'd80;
  localparam logic [8:0] LOW_LIMIT_RESET    = 9'd20;
  localparam logic [7:0] TOP_POSITION_RESET = 8'd175;

  localparam logic       CMD_SAMPLE = 1'b0;
  localparam logic       CMD_TICK   = 1'b1;

  localparam logic [3:0] PHASE_A  = 4'd9;
  localparam logic [3:0] PHASE_B  = 4'd12;
  localparam logic [3:0] PHASE_C  = 4'd6;
  localparam logic [3:0] PHASE_D  = 4'd3;

  localparam logic [18:0] TEMP_FULL_SCALE = 19'd500;
  localparam logic [19:0] ADC_MAX         = 20'd1023;
  localparam logic [16:0] DIV10_MUL       = 17'd205;
  localparam logic [7:0]  BAND_STEP       = 8'd25;
  localparam logic [5:0]  BAND_SAT_DIGIT  = 6'd12;
  localparam logic [7:0]  POS_MAX         = 8'd255;

  typedef struct packed {
    logic [LIMIT_W-1:0] high_limit;
    logic [LIMIT_W-1:0] low_limit;
    logic [POS_W-1:0]   top_position;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [TEMP_W-1:0] temp;
  } item_t;

  // floor(s * 500 / 1023) by reciprocal estimate and one correction
  function automatic logic [TEMP_W-1:0] temp_from_sample(input logic [SAMPLE_W-1:0] s);
    logic [18:0] x;
    logic [19:0] sum;
    logic [9:0]  q;
    logic [19:0] qm;
    logic [19:0] r;
    x   = 19'(s) * TEMP_FULL_SCALE;
    sum = {1'b0, x} + 20'(x >> 10);
    q   = sum[19:10];
    qm  = {q, 10'd0} - 20'(q);
    r   = {1'b0, x} - qm;
    if (r >= ADC_MAX) begin
      q = q + 10'd1;
    end
    return q[TEMP_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] target_from_temp(input logic [TEMP_W-1:0] temp,
                                                        input cfg_t cfg);
    logic [16:0] prod;
    logic [5:0]  digit;
    logic [5:0]  dm1;
    logic [POS_W-1:0] t;
    prod  = 17'(temp) * DIV10_MUL;
    digit = prod[16:11];
    dm1   = digit - 6'd1;
    if (temp > cfg.high_limit) begin
      t = cfg.top_position;
    end else if (temp < cfg.low_limit) begin
      t = '0;
    end else if (digit == 6'd0) begin
      t = '0;
    end else if (digit >= BAND_SAT_DIGIT) begin
      t = POS_MAX;
    end else begin
      t = 8'({2'b00, dm1} * BAND_STEP);
    end
    return t;
  endfunction

  // rising position: 9 -> 12 -> 6 -> 3 -> 9
  function automatic logic [PHASE_W-1:0] phase_rise(input logic [PHASE_W-1:0] p);
    logic [3:0] v;
    v = {1'b0, p[3:1]};
    if (v == 4'd1) begin
      v = PHASE_A;
    end else if (v == 4'd4) begin
      v = PHASE_B;
    end
    return v;
  endfunction

  // falling position: 9 -> 3 -> 6 -> 12 -> 9
  function automatic logic [PHASE_W-1:0] phase_fall(input logic [PHASE_W-1:0] p);
    logic [4:0] v;
    v = {p, 1'b0};
    if (v == 5'd24) begin
      v = 5'(PHASE_A);
    end else if (v == 5'd18) begin
      v = 5'(PHASE_D);
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/tsp_item_if.sv -----
// input channel of the positioner: command and converter sample
// uses tsp_pkg widths
`default_nettype none

interface tsp_item_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [tsp_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

`default_nettype wire

// ----- src/tsp_result_if.sv -----
// result channel of the positioner: phase, position, goal, moving flag
// uses tsp_pkg widths
`default_nettype none

interface tsp_result_if;
  logic                           valid;
  logic                           ready;
  logic [tsp_pkg::PHASE_W-1:0]    phase;
  logic [tsp_pkg::POS_W-1:0]      position;
  logic [tsp_pkg::POS_W-1:0]      goal;
  logic                           moving;

  modport source (output valid, output phase, output position, output goal,
                  output moving, input ready);
  modport sink (input valid, input phase, input position, input goal,
                input moving, output ready);
endinterface

`default_nettype wire

// ----- src/tsp_cfg_if.sv -----
// register write channel of the positioner: index and data
// uses tsp_pkg widths
`default_nettype none

interface tsp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsp_pkg::INDEX_W-1:0]    index;
  logic [tsp_pkg::LIMIT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/tsp_cfg_regs.sv -----
// configuration registers: high limit, low limit, top position
// depends on tsp_pkg and tsp_cfg_if
`default_nettype none

module tsp_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  tsp_cfg_if.sink       cfg,
  output tsp_pkg::cfg_t regs
);
  import tsp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.high_limit   <= HIGH_LIMIT_RESET;
      regs.low_limit    <= LOW_LIMIT_RESET;
      regs.top_position <= TOP_POSITION_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HIGH_LIMIT:   regs.high_limit   <= cfg.data;
        REG_LOW_LIMIT:    regs.low_limit    <= cfg.data;
        REG_TOP_POSITION: regs.top_position <= cfg.data[POS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/tsp_front.sv -----
// input register: accepts an item and converts the sample to whole degrees
// depends on tsp_pkg and tsp_item_if
`default_nettype none

module tsp_front (
  input  logic           clk,
  input  logic           rst,
  tsp_item_if.sink       item,
  input  logic           take,
  output tsp_pkg::item_t staged
);
  import tsp_pkg::*;

  logic accept;

  assign item.ready = !staged.valid || take;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      staged.valid <= 1'b0;
    end else if (accept) begin
      staged.valid <= 1'b1;
    end else if (take) begin
      staged.valid <= 1'b0;
    end
    if (accept) begin
      staged.cmd  <= item.cmd;
      staged.temp <= temp_from_sample(item.sample);
    end
  end

endmodule

`default_nettype wire

// ----- src/tsp_core.sv -----
// motor state and result register: target update, stepping, coil pattern
// depends on tsp_pkg and tsp_result_if
`default_nettype none

module tsp_core (
  input  logic           clk,
  input  logic           rst,
  input  tsp_pkg::item_t staged,
  input  tsp_pkg::cfg_t  regs,
  output logic           take,
  tsp_result_if.source   result
);
  import tsp_pkg::*;

  logic [POS_W-1:0]   position;
  logic [PHASE_W-1:0] phase;
  logic [POS_W-1:0]   target;
  logic               out_valid;

  logic [POS_W-1:0]   position_next;
  logic [PHASE_W-1:0] phase_next;
  logic [POS_W-1:0]   target_next;

  assign take         = staged.valid && (!out_valid || result.ready);
  assign result.valid = out_valid;

  always_comb begin
    position_next = position;
    phase_next    = phase;
    target_next   = target;
    priority if (staged.cmd == CMD_SAMPLE) begin
      target_next = target_from_temp(staged.temp, regs);
    end else if (target > position) begin
      phase_next    = phase_rise(phase);
      position_next = position + 8'd1;
    end else if (target < position) begin
      phase_next    = phase_fall(phase);
      position_next = position - 8'd1;
    end else begin
      position_next = position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      phase     <= PHASE_A;
      target    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        position <= position_next;
        phase    <= phase_next;
        target   <= target_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.phase    <= phase_next;
      result.position <= position_next;
      result.goal     <= target_next;
      result.moving   <= position_next != target_next;
    end
  end

`ifndef ASSERT_OFF
  a_phase_in_cycle: assert property (@(posedge clk) disable iff (rst)
    phase == PHASE_A || phase == PHASE_B || phase == PHASE_C || phase == PHASE_D)
    else $error("coil pattern left the full-step cycle");

  a_sample_holds_position: assert property (@(posedge clk) disable iff (rst)
    take && staged.cmd == CMD_SAMPLE |=> position == $past(position) && phase == $past(phase))
    else $error("sample moved the motor");

  a_tick_steps: assert property (@(posedge clk) disable iff (rst)
    take && staged.cmd == CMD_TICK && position != target |=> position != $past(position))
    else $error("tick away from target did not step");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.position == position && result.goal == target && result.phase == phase)
    else $error("held result disagrees with motor state");
`endif

endmodule

`default_nettype wire

// ----- src/temperature_stepper_positioner.sv -----
// temperature driven stepper positioner, full-step two-phase drive
// usage:
//   item channel carries cmd and sample; cmd 0 is a converter sample that sets
//   the target position, cmd 1 is a step tick that moves one step toward it
//   result channel gives one transfer per item: coil phase, position, goal and
//   a moving flag, all as they stand after that item
//   cfg channel writes high limit, low limit and top position; always ready;
//   writes must be made while no item is in flight; the block does not enforce it
// path: the item passes the input register (temperature conversion), then the
//   result register (target and step logic) before result valid
// throughput: one item per cycle while result ready is high; item and result
//   registers hand over in the same cycle, freeing the input register at once
// stall: when the receiver holds ready low the result is kept, one more item
//   waits in the input register, then item ready drops
// reset: rst is synchronous; position and target go to 0, phase to 9, limits
//   to 80 and 20, top position to 175, and both registers empty
// depends on tsp_pkg, the channel interfaces and the tsp_* modules
`default_nettype none

module temperature_stepper_positioner (
  input  logic         clk,
  input  logic         rst,
  tsp_item_if.sink     item,
  tsp_result_if.source result,
  tsp_cfg_if.sink      cfg
);
  import tsp_pkg::*;

  cfg_t  regs;
  item_t staged;
  logic  take;

  tsp_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tsp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .take   (take),
    .staged (staged)
  );

  tsp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .staged (staged),
    .regs   (regs),
    .take   (take),
    .result (result)
  );

endmodule

`default_nettype wire
